// ----- sv/kmc_pkg.sv -----
// shared constants and types of the minimum spanning tree cost block
// used by the top level, the controller and the datapath; depends on nothing
package kmc_pkg;

  localparam int MAX_NODES  = 64;
  localparam int MAX_EDGES  = 256;
  localparam int COST_BITS  = 16;

  localparam int NODE_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
  localparam int FILL_W     = $clog2(MAX_EDGES + 1);
  localparam int TOTAL_W    = 22;
  localparam int USED_W     = 6;
  localparam int KEY_W      = COST_BITS + EDGE_IDX_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(MAX_NODES);

  typedef struct packed {
    logic [NODE_W-1:0] edge_source;
    logic [NODE_W-1:0] edge_destination;
    logic [15:0]       edge_cost;
    logic              last_edge;
  } edge_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_cost;
    logic [USED_W-1:0]  edges_used;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic [NODE_W-1:0]    src;
    logic [NODE_W-1:0]    dst;
    logic [COST_BITS-1:0] cost;
  } edge_rec_t;

  localparam int EDGE_REC_W = $bits(edge_rec_t);

  typedef struct packed {
    logic store;        // write accepted edge request
    logic start;        // clear union-find state and sums
    logic scan_init;
    logic scan;
    logic advance;      // selected edge becomes the previous key
    logic root_init;
    logic follow;
    logic root_a;
    logic unite;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic scan_done;
    logic best_found;
    logic edge_ok;
    logic is_root;
    logic roots_differ;
  } sts_t;

endpackage

// ----- sv/kruskal_mst_cost_top.sv -----
// top level of the minimum spanning tree cost block
// depends on kmc_pkg, kmc_ctrl and kmc_dp (which holds two kmc_ram instances)
//
// Edge requests load one per cycle into a 256-entry edge store; requests past
// that are dropped and flagged in the result. A request marked last starts the
// computation and stalls the edge channel until it ends. Each edge taken in
// ascending cost order costs one full scan of the store plus the parent-table
// reads of its two root walks, each read passing through ROOT_RD and ROOT_CHK.
// The scan length is set by the single read port of the edge store. The result
// then waits in an output register while the next set already loads.
module kruskal_mst_cost_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              edge_valid,
  output logic                              edge_ready,
  input  kmc_pkg::edge_req_t                edge_req,
  output logic                              result_valid,
  input  logic                              result_ready,
  output kmc_pkg::result_t                  result,
  input  logic                              node_count_valid,
  output logic                              node_count_ready,
  input  logic [kmc_pkg::COUNT_W-1:0]       node_count
);
  import kmc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign node_count_ready = 1'b1;

  kmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .edge_valid   (edge_valid),
    .edge_ready   (edge_ready),
    .last_edge    (edge_req.last_edge),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  kmc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .edge_req (edge_req),
    .cfg_we   (node_count_valid),
    .cfg_data (node_count),
    .result   (result)
  );

endmodule

// ----- sv/kmc_ram.sv -----
// generic single write, single read memory with registered read data
// no dependencies
module kmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/kmc_ctrl.sv -----
// controller: sequences loading, minimum selection scans and root walks
// depends on kmc_pkg
module kmc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          edge_valid,
  output logic          edge_ready,
  input  logic          last_edge,
  output logic          result_valid,
  input  logic          result_ready,
  input  kmc_pkg::sts_t sts,
  output kmc_pkg::cmd_t cmd
);
  import kmc_pkg::*;

  typedef enum logic [2:0] {
    LOAD, SCAN_START, SCAN, PICK, ROOT_RD, ROOT_CHK, FINISH
  } state_t;

  state_t state;
  logic   second;
  logic   out_free;

  assign edge_ready = (state == LOAD);
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      LOAD: begin
        cmd.store = edge_valid;
        cmd.start = edge_valid && last_edge;
      end
      SCAN_START: cmd.scan_init = !sts.stop;
      SCAN:       cmd.scan = 1'b1;
      PICK: begin
        cmd.advance   = sts.best_found;
        cmd.root_init = sts.best_found && sts.edge_ok;
      end
      ROOT_RD: ;
      ROOT_CHK: begin
        cmd.follow = !sts.is_root;
        cmd.root_a = sts.is_root && !second;
        cmd.unite  = sts.is_root && second && sts.roots_differ;
      end
      FINISH: cmd.load_result = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      second       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // in FINISH a new result replaces the one leaving
      if (result_valid && result_ready && state != FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        LOAD: begin
          if (edge_valid && last_edge) begin
            state <= SCAN_START;
          end
        end
        SCAN_START: state <= sts.stop ? FINISH : SCAN;
        SCAN: begin
          if (sts.scan_done) begin
            state <= PICK;
          end
        end
        PICK: begin
          if (!sts.best_found) begin
            state <= FINISH;
          end else if (sts.edge_ok) begin
            second <= 1'b0;
            state  <= ROOT_RD;
          end else begin
            state <= SCAN_START;
          end
        end
        ROOT_RD: state <= ROOT_CHK;
        ROOT_CHK: begin
          if (!sts.is_root) begin
            state <= ROOT_RD;
          end else if (!second) begin
            second <= 1'b1;
            state  <= ROOT_RD;
          end else begin
            state <= SCAN_START;
          end
        end
        FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= LOAD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

endmodule

// ----- sv/kmc_dp.sv -----
// datapath: edge store, selection scan, parent table and cost accumulation
// depends on kmc_pkg and kmc_ram
module kmc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kmc_pkg::cmd_t                 cmd,
  output kmc_pkg::sts_t                 sts,
  input  kmc_pkg::edge_req_t            edge_req,
  input  logic                          cfg_we,
  input  logic [kmc_pkg::COUNT_W-1:0]   cfg_data,
  output kmc_pkg::result_t              result
);
  import kmc_pkg::*;

  logic [COUNT_W-1:0]    node_count_q;
  logic [COUNT_W-1:0]    n_eff;
  logic [FILL_W-1:0]     fill;
  logic                  ovf;
  logic                  store_en;

  logic [FILL_W-1:0]     scan_idx;
  logic                  rd_vld;
  logic [EDGE_IDX_W-1:0] rd_idx;
  logic [EDGE_REC_W-1:0] edge_rd;
  edge_rec_t             rd_edge;
  logic [KEY_W-1:0]      rd_key;
  logic                  better;

  logic [KEY_W-1:0]      best_key;
  logic [NODE_W-1:0]     best_src;
  logic [NODE_W-1:0]     best_dst;
  logic                  best_found;
  logic [KEY_W-1:0]      prev_key;
  logic                  has_prev;

  logic [NODE_W-1:0]     v;
  logic [NODE_W-1:0]     ra;
  logic [NODE_W-1:0]     par_rd;
  logic [NODE_W-1:0]     p;
  logic [MAX_NODES-1:0]  pvalid;

  logic [TOTAL_W-1:0]    sum;
  logic [TOTAL_W:0]      sum_add;
  logic [USED_W-1:0]     acc;
  logic [COST_BITS-1:0]  best_cost;

  edge_rec_t             wr_edge;

  assign n_eff    = (node_count_q > NODE_LIMIT) ? NODE_LIMIT : node_count_q;
  assign store_en = cmd.store && (fill < FILL_W'(MAX_EDGES));

  assign wr_edge.src  = edge_req.edge_source;
  assign wr_edge.dst  = edge_req.edge_destination;
  assign wr_edge.cost = edge_req.edge_cost[COST_BITS-1:0];

  kmc_ram #(.WIDTH(EDGE_REC_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (fill[EDGE_IDX_W-1:0]),
    .wr_data (wr_edge),
    .rd_addr (scan_idx[EDGE_IDX_W-1:0]),
    .rd_data (edge_rd)
  );

  kmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk     (clk),
    .wr_en   (cmd.unite),
    .wr_addr (ra),
    .wr_data (v),
    .rd_addr (v),
    .rd_data (par_rd)
  );

  // key orders by cost, then arrival, so repeated scans give a stable sort
  assign rd_edge = edge_rec_t'(edge_rd);
  assign rd_key  = {rd_edge.cost, rd_idx};
  assign better  = (!has_prev || rd_key > prev_key) && (!best_found || rd_key < best_key);

  // entry without a valid bit is its own parent
  assign p         = pvalid[v] ? par_rd : v;
  assign best_cost = best_key[KEY_W-1 -: COST_BITS];
  assign sum_add   = {1'b0, sum} + (TOTAL_W+1)'(best_cost);

  assign sts.stop         = (n_eff == '0) || ({1'b0, acc} >= n_eff - 1'b1);
  assign sts.scan_done    = (scan_idx == fill) && !rd_vld;
  assign sts.best_found   = best_found;
  assign sts.edge_ok      = ({1'b0, best_src} < n_eff) && ({1'b0, best_dst} < n_eff);
  assign sts.is_root      = (p == v);
  assign sts.roots_differ = (ra != v);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count_q <= NODE_LIMIT;
      fill         <= '0;
      ovf          <= 1'b0;
      rd_vld       <= 1'b0;
      best_found   <= 1'b0;
      has_prev     <= 1'b0;
      pvalid       <= '0;
      sum          <= '0;
      acc          <= '0;
      scan_idx     <= '0;
    end else begin
      if (cfg_we) begin
        node_count_q <= cfg_data;
      end
      if (cmd.store) begin
        if (store_en) begin
          fill <= fill + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.start) begin
        pvalid   <= '0;
        sum      <= '0;
        acc      <= '0;
        has_prev <= 1'b0;
      end
      if (cmd.scan_init) begin
        scan_idx   <= '0;
        rd_vld     <= 1'b0;
        best_found <= 1'b0;
      end
      if (cmd.scan) begin
        if (scan_idx < fill) begin
          rd_vld   <= 1'b1;
          rd_idx   <= scan_idx[EDGE_IDX_W-1:0];
          scan_idx <= scan_idx + 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
        if (rd_vld && better) begin
          best_found <= 1'b1;
          best_key   <= rd_key;
          best_src   <= rd_edge.src;
          best_dst   <= rd_edge.dst;
        end
      end
      if (cmd.advance) begin
        prev_key <= best_key;
        has_prev <= 1'b1;
      end
      if (cmd.root_init) begin
        v <= best_src;
      end
      if (cmd.follow) begin
        v <= p;
      end
      if (cmd.root_a) begin
        ra <= v;
        v  <= best_dst;
      end
      if (cmd.unite) begin
        pvalid[ra] <= 1'b1;
        sum        <= sum_add[TOTAL_W] ? TOTAL_MAX : sum_add[TOTAL_W-1:0];
        acc        <= acc + 1'b1;
      end
      if (cmd.load_result) begin
        result.total_cost <= sum;
        result.edges_used <= acc;
        result.overflow   <= ovf;
        fill              <= '0;
        ovf               <= 1'b0;
      end
    end
  end

endmodule
